// File: rtl/sos_pkg.sv
// Shared types and constants for the set-of-stacks block.
`default_nettype none

package sos_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CAP_WIDTH  = 5;
    localparam int IDX_WIDTH  = 4;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd4;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_POP_AT = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_ZEROCAP = 2'd3
    } status_t;

    typedef struct packed {
        op_t                           op;
        logic signed [WORD_WIDTH-1:0]  push_value;
        logic [IDX_WIDTH-1:0]          stack_index;
    } request_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0]  pop_value;
        status_t                       status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic cap_write;
    } sos_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
    } sos_stat_t;

endpackage

`default_nettype wire

// File: rtl/sos_ctrl.sv
// Controller: request sequencing, busy and result strobe.
`default_nettype none

module sos_ctrl
    import sos_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      cfg_we,
    input  wire sos_stat_t stat,
    output sos_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = accept ? S_ACT : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy      <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy      <= (state_next == S_ACT);
            done      <= (state_next == S_RESP);
        end
    end

    assign cmd.capture   = accept;
    assign cmd.execute   = (state_reg == S_ACT);
    // Capacity changes only while no sub-stack exists
    assign cmd.cap_write = cfg_we && stat.empty && (state_reg != S_ACT);

endmodule

`default_nettype wire

// File: rtl/sos_dp.sv
// Datapath: plate memory, fill counts, slot order table and result register.
`default_nettype none

module sos_dp
    import sos_pkg::*;
#(
    parameter int MAX_STACKS   = 16,
    parameter int MAX_CAPACITY = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sos_cmd_t             cmd,
    input  wire request_t             req,
    input  wire logic [CAP_WIDTH-1:0] cfg_wdata,
    output sos_stat_t                 stat,
    output result_t                   rsp
);

    localparam int SW    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int TW    = $clog2(MAX_STACKS + 1);
    localparam int FW    = $clog2(MAX_CAPACITY + 1);
    localparam int CW    = (FW > CAP_WIDTH) ? FW : CAP_WIDTH;
    localparam int DEPTH = MAX_STACKS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (TW > IDX_WIDTH) ? TW : IDX_WIDTH;

    logic [WORD_WIDTH-1:0] plate_mem [DEPTH];
    logic [WORD_WIDTH-1:0] rdata_reg;

    logic [FW-1:0]        fill_reg  [MAX_STACKS];
    logic [FW-1:0]        fill_next [MAX_STACKS];
    logic [SW-1:0]        order_reg  [MAX_STACKS];
    logic [SW-1:0]        order_next [MAX_STACKS];
    logic [TW-1:0]        total_reg;
    logic [TW-1:0]        total_next;
    logic [CAP_WIDTH-1:0] capacity_reg;

    // Request captured with its slot lookups
    op_t                  op_reg;
    logic [WORD_WIDTH-1:0] val_reg;
    logic [SW-1:0]        idx_reg;
    logic                 idx_hit_reg;
    logic [SW-1:0]        phys_last_reg;
    logic [SW-1:0]        phys_new_reg;
    logic [SW-1:0]        phys_idx_reg;

    logic                 idx_hit;
    logic [SW-1:0]        phys_last;
    logic [SW-1:0]        phys_new;
    logic [SW-1:0]        phys_idx;

    status_t              status_reg;
    status_t              status_next;
    logic                 pop_ok_reg;
    logic                 pop_ok_next;
    logic                 push_ok_reg;
    logic                 push_ok_next;

    logic [FW-1:0]        fill_last;
    logic [FW-1:0]        fill_idx;
    logic [CW-1:0]        cap_eff;
    logic                 mem_we;
    logic                 mem_re;
    logic [SW-1:0]        mem_slot;
    logic [FW-1:0]        mem_off;
    logic [AW-1:0]        mem_addr;
    logic                 fill_we;
    logic [SW-1:0]        fill_sel;
    logic [FW-1:0]        fill_val;
    logic                 remove;

    // Slot lookups for the incoming request
    always_comb
    begin
        idx_hit   = XW'(req.stack_index) < XW'(total_reg);
        phys_last = (total_reg != '0) ? order_reg[SW'(total_reg - 1'b1)] : '0;
        phys_new  = (total_reg < TW'(MAX_STACKS)) ? order_reg[total_reg[SW-1:0]] : '0;
        phys_idx  = idx_hit ? order_reg[SW'(req.stack_index)] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= req.op;
            val_reg       <= req.push_value;
            idx_reg       <= SW'(req.stack_index);
            idx_hit_reg   <= idx_hit;
            phys_last_reg <= phys_last;
            phys_new_reg  <= phys_new;
            phys_idx_reg  <= phys_idx;
        end
    end

    always_comb
    begin
        fill_last = fill_reg[phys_last_reg];
        fill_idx  = fill_reg[phys_idx_reg];
        cap_eff   = (CW'(capacity_reg) > CW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY)
                                                            : CW'(capacity_reg);
    end

    // Operation decode
    always_comb
    begin
        status_next  = ST_EMPTY;
        pop_ok_next  = 1'b0;
        push_ok_next = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_slot     = phys_last_reg;
        mem_off      = fill_last;
        fill_we      = 1'b0;
        fill_sel     = phys_last_reg;
        fill_val     = fill_last;
        total_next   = total_reg;
        remove       = 1'b0;
        case (op_reg)
            OP_PUSH:
            begin
                if (cap_eff == '0)
                begin
                    status_next = ST_ZEROCAP;
                end
                else if ((total_reg == '0) || (CW'(fill_last) >= cap_eff))
                begin
                    if (total_reg >= TW'(MAX_STACKS))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // Open a new sub-stack in the next free slot
                        mem_we       = 1'b1;
                        mem_slot     = phys_new_reg;
                        mem_off      = '0;
                        fill_we      = 1'b1;
                        fill_sel     = phys_new_reg;
                        fill_val     = FW'(1);
                        total_next   = total_reg + 1'b1;
                        status_next  = ST_OK;
                        push_ok_next = 1'b1;
                    end
                end
                else
                begin
                    mem_we       = 1'b1;
                    fill_we      = 1'b1;
                    fill_val     = fill_last + 1'b1;
                    status_next  = ST_OK;
                    push_ok_next = 1'b1;
                end
            end
            OP_POP:
            begin
                if (total_reg != '0)
                begin
                    mem_re      = 1'b1;
                    mem_off     = fill_last - 1'b1;
                    fill_we     = 1'b1;
                    fill_val    = fill_last - 1'b1;
                    status_next = ST_OK;
                    pop_ok_next = 1'b1;
                    if (fill_last == FW'(1))
                    begin
                        total_next = total_reg - 1'b1;
                    end
                end
            end
            OP_POP_AT:
            begin
                if (idx_hit_reg)
                begin
                    mem_re      = 1'b1;
                    mem_slot    = phys_idx_reg;
                    mem_off     = fill_idx - 1'b1;
                    fill_we     = 1'b1;
                    fill_sel    = phys_idx_reg;
                    fill_val    = fill_idx - 1'b1;
                    status_next = ST_OK;
                    pop_ok_next = 1'b1;
                    if (fill_idx == FW'(1))
                    begin
                        remove     = 1'b1;
                        total_next = total_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_EMPTY;
            end
        endcase
    end

    assign mem_addr = AW'(AW'(mem_slot) * AW'(MAX_CAPACITY)) + AW'(mem_off);

    always_comb
    begin
        for (int k = 0; k < MAX_STACKS; k++)
        begin
            fill_next[k]  = fill_reg[k];
            order_next[k] = order_reg[k];
        end
        if (fill_we)
        begin
            fill_next[fill_sel] = fill_val;
        end
        if (remove)
        begin
            // Close the gap and park the emptied slot after the live ones
            for (int k = 0; k < MAX_STACKS - 1; k++)
            begin
                if ((SW'(k) >= idx_reg) && (k + 1 < int'(total_reg)))
                begin
                    order_next[k] = order_reg[k + 1];
                end
            end
            order_next[SW'(total_reg - 1'b1)] = phys_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_STACKS; k++)
            begin
                fill_reg[k]  <= '0;
                order_reg[k] <= SW'(k);
            end
            total_reg    <= '0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            if (cmd.execute)
            begin
                for (int k = 0; k < MAX_STACKS; k++)
                begin
                    fill_reg[k]  <= fill_next[k];
                    order_reg[k] <= order_next[k];
                end
                total_reg <= total_next;
            end
            if (cmd.cap_write)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            plate_mem[mem_addr] <= val_reg;
        end
        if (cmd.execute && mem_re)
        begin
            rdata_reg <= plate_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg  <= status_next;
            pop_ok_reg  <= pop_ok_next;
            push_ok_reg <= push_ok_next;
        end
    end

    assign stat.empty    = (total_reg == '0);
    assign rsp.status    = status_reg;
    assign rsp.pop_value = pop_ok_reg  ? rdata_reg :
                           push_ok_reg ? '0 : {WORD_WIDTH{1'b1}};

endmodule

`default_nettype wire

// File: rtl/set_of_stacks_with_pop_at_top.sv
// Top level of the set of stacks with pop from last and pop at index.
//
//  channel   handshake           payload      notes
//  request   start / busy        req          taken when start && !busy
//  result    done                rsp          one cycle, no back-pressure
//  config    cfg_we              cfg_wdata    capacity, kept only while empty
//
// For each request the slot order lookup is registered at accept, the next
// cycle updates fill counts and the order table and accesses the plate
// memory, and the result is strobed in the cycle after that while the next
// request may already be accepted. The plate memory's registered read port
// sets the latency. Reset clears all sub-stacks and sets capacity to 4;
// no clearing pass is needed.
`default_nettype none

module set_of_stacks_with_pop_at_top
    import sos_pkg::*;
#(
    parameter int MAX_STACKS   = 16,
    parameter int MAX_CAPACITY = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire request_t             req,
    output logic                      done,
    output result_t                   rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CAP_WIDTH-1:0] cfg_wdata
);

    sos_cmd_t  cmd;
    sos_stat_t stat;

    sos_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sos_dp #(
        .MAX_STACKS   (MAX_STACKS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .rsp       (rsp)
    );

    // An accepted request is executed next cycle and answered the one after
    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 done)
        else $error("request not answered two cycles after accept");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobed while request executes");

    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.pop_value == {WORD_WIDTH{1'b1}}))
        else $error("failed request returned a value other than all ones");

    // Hold capacity while any sub-stack is live
    a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.empty |=> $stable(u_dp.capacity_reg))
        else $error("capacity changed while store not empty");

endmodule

`default_nettype wire
